// File: rtl/btpc_pkg.sv
// Package for the barometric compensation pipeline: shared types, register
// indexes, calibration layout and the round-to-nearest helper.
// No dependencies.
package btpc_pkg;

    localparam int FRAC_BITS_DEF = 32;
    localparam int CFG_IDX_W     = 8;
    localparam int CFG_DATA_W    = 48;

    localparam logic [CFG_IDX_W-1:0] REG_TEMP_CALIB    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_A = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_B = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_CALIB_C = 8'd3;

    typedef logic signed [63:0]  s64_t;
    typedef logic signed [127:0] s128_t;

    typedef struct packed {
        logic [15:0]       t1;
        logic [15:0]       t2;
        logic signed [7:0] t3;
    } btpc_tcal_t;

    typedef struct packed {
        logic              valid;
        logic              sat;
        s64_t              tq;
        logic [23:0]       rp;
        logic signed [15:0] tout;
    } btpc_temp_t;

    // round(v / 2^s), ties away from zero
    function automatic s128_t btpc_rnd(s128_t v, int s);
        s128_t h;
        s128_t adj;
        if (s <= 0)
        begin
            return v;
        end
        h   = s128_t'(1) <<< (s - 1);
        adj = (v < 0) ? s128_t'(1) : s128_t'(0);
        return (v + h - adj) >>> s;
    endfunction

endpackage

// File: rtl/btpc_temp.sv
// Temperature front end: linearised temperature over four register stages.
// Depends on btpc_pkg.
module btpc_temp
    import btpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic [23:0] raw_t,
    input  logic [23:0] raw_p,
    input  btpc_tcal_t  tcal,
    output btpc_temp_t  res
);

    localparam s64_t T_MIN = -(64'sd40 <<< 48);
    localparam s64_t T_MAX = 64'sd85 <<< 48;

    logic               valid_reg [1:4];
    logic [23:0]        rp_reg    [1:4];
    logic signed [25:0] d_reg;
    logic signed [42:0] a_reg;
    logic signed [51:0] dd_reg;
    s64_t               n_reg;
    s64_t               tq_reg;
    logic               sat_reg;
    logic signed [25:0] d_next;
    s64_t               nc_next;
    logic               sat_next;

    assign d_next = $signed({2'b00, raw_t}) - $signed({2'b00, tcal.t1, 8'h00});

    always_comb
    begin
        nc_next  = n_reg;
        sat_next = 1'b0;
        if (n_reg < T_MIN)
        begin
            nc_next  = T_MIN;
            sat_next = 1'b1;
        end
        else if (n_reg > T_MAX)
        begin
            nc_next  = T_MAX;
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= 4; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[1] <= in_valid;
            for (int k = 2; k <= 4; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg[1] <= raw_p;
        for (int k = 2; k <= 4; k++)
        begin
            rp_reg[k] <= rp_reg[k-1];
        end
        d_reg   <= d_next;
        a_reg   <= d_reg * $signed({1'b0, tcal.t2});
        dd_reg  <= d_reg * d_reg;
        n_reg   <= (s64_t'(a_reg) <<< 18) + s64_t'(dd_reg) * s64_t'(tcal.t3);
        tq_reg  <= s64_t'(btpc_rnd(s128_t'(nc_next), 48 - FRAC_BITS));
        sat_reg <= sat_next;
    end

    assign res.valid = valid_reg[4];
    assign res.sat   = sat_reg;
    assign res.tq    = tq_reg;
    assign res.rp    = rp_reg[4];
    assign res.tout  = 16'(btpc_rnd(s128_t'(tq_reg), FRAC_BITS - 8));

endmodule

// File: rtl/baro_temp_pressure_compensation_unit.sv
// Top level of the barometric temperature and pressure compensation pipeline.
// Depends on btpc_pkg and btpc_temp.
//
// Usage:
//   Calibration is written over the cfg channel (cfg_valid/cfg_ready,
//   cfg_index, cfg_data). Index 0 temp_calib, 1..3 press_calib_a..c; other
//   indexes are ignored. cfg_ready is always high. Write only while no item
//   is in flight.
//   An item (raw_temperature, raw_pressure) is taken on each edge where start
//   is high; busy stays low, so one item per cycle is sustained.
//   Each item gives one result, shown for one cycle with result_valid high.
//   The pipeline has 13 register stages: four for the temperature front
//   end, then the Horner chains in temperature, each step one multiply
//   stage and one round/add stage, then the final pressure product, sum,
//   round and clamp.
//   The receiver cannot stall; results are never held.
//   Reset clears the calibration registers to zero and empties the pipeline;
//   no result appears until a new item is taken.
module baro_temp_pressure_compensation_unit
    import btpc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [23:0]           raw_temperature,
    input  logic [23:0]           raw_pressure,
    output logic                  result_valid,
    output logic signed [15:0]    temperature,
    output logic [20:0]           pressure,
    output logic                  saturated,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam s64_t P_MAX = 64'sd2097151;
    localparam int   TQ_W  = FRAC_BITS + 8;

    logic [39:0] temp_calib_reg;
    logic [47:0] press_calib_a_reg;
    logic [47:0] press_calib_b_reg;
    logic [31:0] press_calib_c_reg;

    btpc_tcal_t tcal;
    btpc_temp_t tr;
    s64_t p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;

    logic               valid_reg [5:12];
    s64_t               tq_reg    [5:8];
    logic [23:0]        rp_reg    [5:10];
    logic               sat_reg   [5:12];
    logic signed [15:0] tout_reg  [5:12];

    s128_t m8_reg, m4_reg, m10_reg;
    s64_t  rp11_reg;
    logic [47:0] rp2_reg [5:8];
    s64_t  x1_reg, x2_reg;
    s64_t  dq_reg  [6:8];
    logic signed [TQ_W-1:0]  tq6_n, tq8_n;
    logic signed [TQ_W+24:0] mx1_lo_reg, mx2_lo_reg;
    logic signed [TQ_W+13:0] mx1_hi_reg, mx2_hi_reg;
    s64_t  y1_reg, y2_reg;
    logic signed [TQ_W+24:0] my1_lo_reg, my2_lo_reg;
    logic signed [TQ_W+23:0] my1_hi_reg, my2_hi_reg;
    logic [47:0]        m3_ll_reg, m3_hl_reg;
    logic signed [49:0] m3_lh_reg, m3_hh_reg;
    s64_t  out1_reg [10:11];
    s64_t  out3_reg [10:11];
    s64_t  c2_reg;
    logic signed [53:0] mc_lo_reg, mc_hi_reg;
    s64_t  sum_reg;

    logic               result_valid_reg;
    logic signed [15:0] temperature_reg;
    logic [20:0]        pressure_reg;
    logic               saturated_reg;

    s64_t  pq_next;
    logic [20:0] pressure_next;
    logic  psat_next;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_calib_reg    <= '0;
            press_calib_a_reg <= '0;
            press_calib_b_reg <= '0;
            press_calib_c_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_TEMP_CALIB:    temp_calib_reg    <= cfg_data[39:0];
                REG_PRESS_CALIB_A: press_calib_a_reg <= cfg_data;
                REG_PRESS_CALIB_B: press_calib_b_reg <= cfg_data;
                REG_PRESS_CALIB_C: press_calib_c_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    assign tcal.t1 = temp_calib_reg[15:0];
    assign tcal.t2 = temp_calib_reg[31:16];
    assign tcal.t3 = $signed(temp_calib_reg[39:32]);

    assign p1  = s64_t'($signed(press_calib_a_reg[15:0]));
    assign p2  = s64_t'($signed(press_calib_a_reg[31:16]));
    assign p3  = s64_t'($signed(press_calib_a_reg[39:32]));
    assign p4  = s64_t'($signed(press_calib_a_reg[47:40]));
    assign p5  = s64_t'($signed({1'b0, press_calib_b_reg[15:0]}));
    assign p6  = s64_t'($signed({1'b0, press_calib_b_reg[31:16]}));
    assign p7  = s64_t'($signed(press_calib_b_reg[39:32]));
    assign p8  = s64_t'($signed(press_calib_b_reg[47:40]));
    assign p9  = s64_t'($signed(press_calib_c_reg[15:0]));
    assign p10 = s64_t'($signed(press_calib_c_reg[23:16]));
    assign p11 = s64_t'($signed(press_calib_c_reg[31:24]));

    assign tq6_n = TQ_W'(tq_reg[6]);
    assign tq8_n = TQ_W'(tq_reg[8]);

    btpc_temp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_temp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (start && !busy),
        .raw_t    (raw_temperature),
        .raw_p    (raw_pressure),
        .tcal     (tcal),
        .res      (tr)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 5; k <= 12; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
            result_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg[5] <= tr.valid;
            for (int k = 6; k <= 12; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
            result_valid_reg <= valid_reg[12];
        end
    end

    always_ff @(posedge clk)
    begin
        tq_reg[5]   <= tr.tq;
        rp_reg[5]   <= tr.rp;
        sat_reg[5]  <= tr.sat;
        tout_reg[5] <= tr.tout;
        for (int k = 6; k <= 8; k++)
        begin
            tq_reg[k] <= tq_reg[k-1];
        end
        for (int k = 6; k <= 10; k++)
        begin
            rp_reg[k] <= rp_reg[k-1];
        end
        for (int k = 6; k <= 12; k++)
        begin
            sat_reg[k]  <= sat_reg[k-1];
            tout_reg[k] <= tout_reg[k-1];
        end

        // stage 5: first products in temperature and pressure
        m8_reg     <= s128_t'(tr.tq) * (s128_t'(p8) <<< 17);
        m4_reg     <= s128_t'(tr.tq) * (s128_t'(p4) <<< 23);
        m10_reg    <= s128_t'(tr.tq) * (s128_t'(p10) <<< 32);
        rp11_reg   <= s64_t'($signed({1'b0, tr.rp})) * p11;
        rp2_reg[5] <= tr.rp * tr.rp;
        for (int k = 6; k <= 8; k++)
        begin
            rp2_reg[k] <= rp2_reg[k-1];
        end

        // stage 6
        x1_reg    <= (p7 <<< 24) + s64_t'(btpc_rnd(m8_reg, FRAC_BITS));
        x2_reg    <= (p3 <<< 28) + s64_t'(btpc_rnd(m4_reg, FRAC_BITS));
        dq_reg[6] <= (p9 <<< 32) + s64_t'(btpc_rnd(m10_reg, FRAC_BITS))
                     + (rp11_reg <<< 15);
        for (int k = 7; k <= 8; k++)
        begin
            dq_reg[k] <= dq_reg[k-1];
        end

        // stage 7: partial products, low 24 bits and signed upper part
        mx1_lo_reg <= tq6_n * $signed({1'b0, x1_reg[23:0]});
        mx1_hi_reg <= tq6_n * $signed(x1_reg[37:24]);
        mx2_lo_reg <= tq6_n * $signed({1'b0, x2_reg[23:0]});
        mx2_hi_reg <= tq6_n * $signed(x2_reg[37:24]);

        // stage 8
        y1_reg <= (p6 <<< 26) + s64_t'(btpc_rnd((s128_t'(mx1_hi_reg) <<< 24)
                  + s128_t'(mx1_lo_reg), FRAC_BITS));
        y2_reg <= ((p2 - 64'sd16384) <<< 31) + s64_t'(btpc_rnd((s128_t'(mx2_hi_reg) <<< 24)
                  + s128_t'(mx2_lo_reg), FRAC_BITS));

        // stage 9
        my1_lo_reg <= tq8_n * $signed({1'b0, y1_reg[23:0]});
        my1_hi_reg <= tq8_n * $signed(y1_reg[47:24]);
        my2_lo_reg <= tq8_n * $signed({1'b0, y2_reg[23:0]});
        my2_hi_reg <= tq8_n * $signed(y2_reg[47:24]);
        m3_ll_reg  <= rp2_reg[8][23:0] * dq_reg[8][23:0];
        m3_lh_reg  <= $signed({1'b0, rp2_reg[8][23:0]}) * $signed(dq_reg[8][48:24]);
        m3_hl_reg  <= rp2_reg[8][47:24] * dq_reg[8][23:0];
        m3_hh_reg  <= $signed({1'b0, rp2_reg[8][47:24]}) * $signed(dq_reg[8][48:24]);

        // stage 10
        out1_reg[10] <= (p5 <<< 35) + s64_t'(btpc_rnd((s128_t'(my1_hi_reg) <<< 24)
                        + s128_t'(my1_lo_reg), FRAC_BITS));
        c2_reg       <= ((p1 - 64'sd16384) <<< 40) + s64_t'(btpc_rnd(
                        (s128_t'(my2_hi_reg) <<< 24) + s128_t'(my2_lo_reg), FRAC_BITS));
        out3_reg[10] <= s64_t'(btpc_rnd(s128_t'($signed({1'b0, m3_ll_reg}))
                        + ((s128_t'(m3_lh_reg) + s128_t'($signed({1'b0, m3_hl_reg}))) <<< 24)
                        + (s128_t'(m3_hh_reg) <<< 48), 48));
        out1_reg[11] <= out1_reg[10];
        out3_reg[11] <= out3_reg[10];

        // stage 11
        mc_lo_reg <= $signed({1'b0, rp_reg[10]}) * $signed({1'b0, c2_reg[27:0]});
        mc_hi_reg <= $signed({1'b0, rp_reg[10]}) * $signed(c2_reg[56:28]);

        // stage 12
        sum_reg <= out1_reg[11] + s64_t'(btpc_rnd((s128_t'(mc_hi_reg) <<< 28)
                   + s128_t'(mc_lo_reg), 28)) + out3_reg[11];

        // stage 13
        temperature_reg <= tout_reg[12];
        pressure_reg    <= pressure_next;
        saturated_reg   <= sat_reg[12] || psat_next;
    end

    always_comb
    begin
        pq_next       = s64_t'(btpc_rnd(s128_t'(sum_reg), 28));
        psat_next     = 1'b0;
        pressure_next = pq_next[20:0];
        if (pq_next < 0)
        begin
            pressure_next = '0;
            psat_next     = 1'b1;
        end
        else if (pq_next > P_MAX)
        begin
            pressure_next = '1;
            psat_next     = 1'b1;
        end
    end

    assign result_valid = result_valid_reg;
    assign temperature  = temperature_reg;
    assign pressure     = pressure_reg;
    assign saturated    = saturated_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##13 result_valid)
        else $error("result missing after accepted item");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(start, 13))
        else $error("result without accepted item");

    a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (temperature >= -16'sd10240 && temperature <= 16'sd21760))
        else $error("temperature outside clamp range");

endmodule
